FILE: rtl/sobet_pkg.sv
package sobet_pkg;

    localparam int PIXEL_W          = 8;
    localparam int FRAME_WIDTH_W    = 12;
    localparam int FRAME_HEIGHT_W   = 13;
    localparam int THRESH_W         = 11;
    localparam int ROW_W            = 12;
    localparam int MAG_W            = 11;
    localparam int CFG_DATA_W       = 13;

    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int MIN_DIM           = 3;
    localparam int HEIGHT_LIMIT      = 4096;

    localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH    = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT   = 13'd480;
    localparam logic [THRESH_W-1:0]       RST_HIGH_THRESHOLD = 11'd200;
    localparam logic [THRESH_W-1:0]       RST_LOW_THRESHOLD  = 11'd50;

    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_FIFO_AW    = 2;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_HIGH_THRESHOLD = 2'd2,
        REG_LOW_THRESHOLD  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               last;
        logic [PIXEL_W-1:0] value;
    } out_beat_t;

endpackage

FILE: rtl/sobet_line_mem.sv
// Upper and middle line stores side by side in one word: {upper, middle}.
module sobet_line_mem
    import sobet_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [2*PIXEL_W-1:0] wr_data,
    output logic [2*PIXEL_W-1:0] rd_data
);

    logic [2*PIXEL_W-1:0] mem [DEPTH];
    logic [2*PIXEL_W-1:0] rd_data_reg;
    logic [2*PIXEL_W-1:0] fwd_data_reg;
    logic                 fwd_reg;
    logic                 fwd_next;

    // read-first array; a write to the address being read is forwarded
    assign fwd_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_reg      <= fwd_next;
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

FILE: rtl/sobel_edge_threshold_stream.sv
// A pixel beat accepted on s_ passes the stage 1 registers and then the output queue before it can leave on m_.
// Throughput: one pixel per cycle while s_tready is high; each pixel does one read and one write of
// the line store memory, which has one read and one write port.
// s_tready drops only while the 4-beat output queue, counting the beat in stage 1,
// is full, which takes m_tready holding results back.
// Reset (aresetn low, synchronous): position, window and queue are cleared, configuration
// registers take their defaults; line store contents are not cleared.
module sobel_edge_threshold_stream
    import sobet_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: [7:0] pixel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,
    // s_tuser: [0] frame_start
    input  logic                  s_tuser,
    // m_tdata: [7:0] edge_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WCW > FRAME_WIDTH_W) ? WCW : FRAME_WIDTH_W;
    localparam logic [EW-1:0] MAXW_E = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MINW_E = EW'(MIN_DIM);
    localparam logic [FRAME_HEIGHT_W-1:0] MINH_E = FRAME_HEIGHT_W'(MIN_DIM);
    localparam logic [FRAME_HEIGHT_W-1:0] MAXH_E = FRAME_HEIGHT_W'(HEIGHT_LIMIT);

    // configuration
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0]       high_reg;
    logic [THRESH_W-1:0]       low_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            high_reg   <= RST_HIGH_THRESHOLD;
            low_reg    <= RST_LOW_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:    width_reg  <= cfg_data[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT:   height_reg <= cfg_data;
                REG_HIGH_THRESHOLD: high_reg   <= cfg_data[THRESH_W-1:0];
                REG_LOW_THRESHOLD:  low_reg    <= cfg_data[THRESH_W-1:0];
            endcase
        end
    end

    logic [EW-1:0]             eff_w;
    logic [FRAME_HEIGHT_W-1:0] eff_h;

    always_comb begin
        eff_w = EW'(width_reg);
        if (eff_w < MINW_E) begin
            eff_w = MINW_E;
        end else if (eff_w > MAXW_E) begin
            eff_w = MAXW_E;
        end
        eff_h = height_reg;
        if (eff_h < MINH_E) begin
            eff_h = MINH_E;
        end else if (eff_h > MAXH_E) begin
            eff_h = MAXH_E;
        end
    end

    // stage 0: raster position and line store read
    logic                      in_accept;
    logic [CW-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [EW-1:0]             pos_c;
    logic [FRAME_HEIGHT_W-1:0] pos_r;
    logic [CW-1:0]             cur_col;
    logic [ROW_W-1:0]          cur_row;
    logic [EW-1:0]             col_plus;
    logic [FRAME_HEIGHT_W-1:0] row_plus;
    logic                      cur_emit, cur_inner, cur_last;

    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        pos_c = s_tuser ? '0 : EW'(col_reg);
        pos_r = s_tuser ? '0 : FRAME_HEIGHT_W'(row_reg);
        // geometry may have shrunk since the position was stored
        if (pos_c >= eff_w) begin
            pos_c = '0;
            pos_r = pos_r + 1'b1;
        end
        if (pos_r >= eff_h) begin
            pos_r = '0;
        end
        cur_col = pos_c[CW-1:0];
        cur_row = pos_r[ROW_W-1:0];

        col_plus = EW'(cur_col) + 1'b1;
        row_plus = FRAME_HEIGHT_W'(cur_row) + 1'b1;
        if (col_plus >= eff_w) begin
            col_next = '0;
            row_next = (row_plus >= eff_h) ? '0 : row_plus[ROW_W-1:0];
        end else begin
            col_next = col_plus[CW-1:0];
            row_next = cur_row;
        end

        cur_emit  = (cur_row != '0) && (cur_col != '0);
        cur_inner = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
        cur_last  = (FRAME_HEIGHT_W'(cur_row) == eff_h - 1'b1)
                 && (EW'(cur_col) == eff_w - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line data back, window shift, line store write
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_emit_reg, s1_inner_reg, s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
        end
        if (in_accept) begin
            s1_px_reg    <= s_tdata;
            s1_col_reg   <= cur_col;
            s1_emit_reg  <= cur_emit;
            s1_inner_reg <= cur_inner;
            s1_last_reg  <= cur_last;
        end
    end

    logic [2*PIXEL_W-1:0] line_rd;
    logic [2*PIXEL_W-1:0] line_wr;
    logic [PIXEL_W-1:0]   up_px, mid_px;

    assign up_px   = line_rd[2*PIXEL_W-1:PIXEL_W];
    assign mid_px  = line_rd[PIXEL_W-1:0];
    assign line_wr = {mid_px, s1_px_reg};

    sobet_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (in_accept),
        .rd_addr (cur_col),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // window rows: 0 top, 1 middle, 2 bottom; columns: 0 left .. 2 right
    logic [PIXEL_W-1:0] win_reg  [3][3];
    logic [PIXEL_W-1:0] win_next [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = up_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // |Gx| + |Gy| without signed arithmetic
    logic [PIXEL_W+1:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
    logic [MAG_W-1:0]   mag;
    logic [PIXEL_W-1:0] edge_val;

    always_comb begin
        gx_pos = {2'b00, win_next[0][2]} + {1'b0, win_next[1][2], 1'b0}
               + {2'b00, win_next[2][2]};
        gx_neg = {2'b00, win_next[0][0]} + {1'b0, win_next[1][0], 1'b0}
               + {2'b00, win_next[2][0]};
        gy_pos = {2'b00, win_next[2][0]} + {1'b0, win_next[2][1], 1'b0}
               + {2'b00, win_next[2][2]};
        gy_neg = {2'b00, win_next[0][0]} + {1'b0, win_next[0][1], 1'b0}
               + {2'b00, win_next[0][2]};
        gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        mag    = {1'b0, gx_abs} + {1'b0, gy_abs};

        edge_val = '0;
        if (s1_inner_reg) begin
            priority if (mag > high_reg) begin
                edge_val = PIXEL_MAX;
            end else if (mag < low_reg) begin
                edge_val = '0;
            end else if (mag > MAG_W'(PIXEL_MAX)) begin
                edge_val = PIXEL_MAX;
            end else begin
                edge_val = mag[PIXEL_W-1:0];
            end
        end
    end

    // output queue
    out_beat_t               fifo_mem [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OUT_FIFO_AW:0]    count_reg, count_next;
    logic                    push, pop;
    out_beat_t               head;

    assign push = s1_valid_reg && s1_emit_reg;
    assign pop  = m_tvalid && m_tready;
    assign head = fifo_mem[rd_ptr_reg];

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.value;
    assign m_tlast  = head.last;

    // room for the beat in stage 1 and the one about to be taken
    assign s_tready = ((count_reg + (OUT_FIFO_AW+1)'(s1_valid_reg))
                       < (OUT_FIFO_AW+1)'(OUT_FIFO_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= '{last: s1_last_reg, value: edge_val};
        end
    end

endmodule

FILE: rtl/sobet_checker.sv
module sobet_checker
    import sobet_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [PIXEL_W-1:0]    s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [PIXEL_W-1:0]    m_tdata,
    input logic                  m_tlast,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [1:0]            cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // input side only backs up when a result is waiting
    a_ready_low_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with empty output queue");

    a_clean_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> (!m_tvalid && s_tready))
        else $error("output or stall present straight after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind sobel_edge_threshold_stream sobet_checker u_sobet_checker (.*);
